// ----- rtl/weighted_mirror_read_select_unit_assert.svh -----
// Assertion macros for the weighted mirror read-select RTL.
`ifndef WEIGHTED_MIRROR_READ_SELECT_UNIT_ASSERT_SVH
`define WEIGHTED_MIRROR_READ_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define WMRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define WMRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wmrs_pkg.sv -----
// Package with the shared types and constants of the mirror read-select unit.
package wmrs_pkg;

    localparam int COPIES     = 8;
    localparam int IDX_W      = 3;
    localparam int MASK_W     = 8;
    localparam int PREF_W     = 8;
    localparam int WEIGHT_W   = 10;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [MASK_W-1:0]          t_mask;
    typedef logic [PREF_W-1:0]          t_pref;

    localparam t_weight WEIGHT_MIN  = t_weight'({1'b1, {(WEIGHT_W-1){1'b0}}});
    localparam t_weight WEIGHT_ZERO = t_weight'(0);
    localparam t_weight WEIGHT_ONE  = t_weight'(1);

    // Commands from the sequencer to the weight bank.
    typedef struct packed {
        logic              reload;
        logic [COPIES-1:0] reload_mask;
        logic              dec;
        t_idx              dec_idx;
    } t_wb_ctl;

endpackage

// ----- rtl/wmrs_rank.sv -----
// Shared rank unit: finds the highest-weight copy not excluded, lower index on ties.
module wmrs_rank (
    input  wmrs_pkg::t_weight          i_weights [wmrs_pkg::COPIES],
    input  logic [wmrs_pkg::COPIES-1:0] i_excl,
    output logic                        o_have,
    output wmrs_pkg::t_idx              o_best,
    output wmrs_pkg::t_weight           o_best_weight
);
    import wmrs_pkg::*;

    always_comb begin
        o_have        = 1'b0;
        o_best        = '0;
        o_best_weight = WEIGHT_ZERO;
        for (int i = 0; i < COPIES; i++) begin
            if (!i_excl[i] && (!o_have || (i_weights[i] > o_best_weight))) begin
                o_have        = 1'b1;
                o_best        = t_idx'(i);
                o_best_weight = i_weights[i];
            end
        end
    end

endmodule

// ----- rtl/wmrs_weights.sv -----
// Weight bank: preference registers and persistent per-copy read weights.
module wmrs_weights (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  wmrs_pkg::t_idx        i_cfg_index,
    input  wmrs_pkg::t_pref       i_cfg_data,
    input  wmrs_pkg::t_wb_ctl     i_ctl,
    output wmrs_pkg::t_weight     o_weights [wmrs_pkg::COPIES]
);
    import wmrs_pkg::*;

    t_pref   r_pref   [COPIES];
    t_weight r_weight [COPIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COPIES; i++) begin
                r_pref[i]   <= '0;
                r_weight[i] <= WEIGHT_ZERO;
            end
        end else begin
            if (i_cfg_we) begin
                r_pref[i_cfg_index] <= i_cfg_data;
            end
            // Reload and decrement never come in the same cycle.
            for (int i = 0; i < COPIES; i++) begin
                if (i_ctl.reload && i_ctl.reload_mask[i]) begin
                    r_weight[i] <= t_weight'({{(WEIGHT_W-PREF_W){1'b0}}, r_pref[i]})
                                   + WEIGHT_ONE;
                end else if (i_ctl.dec && (i_ctl.dec_idx == t_idx'(i))
                             && (r_weight[i] != WEIGHT_MIN)) begin
                    r_weight[i] <= r_weight[i] - WEIGHT_ONE;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < COPIES; i++) begin
            o_weights[i] = r_weight[i];
        end
    end

endmodule

// ----- rtl/weighted_mirror_read_select_unit.sv -----
// Top level of the weighted mirror read-select unit: sequencer and result register.
//
// Usage: one read request arrives as a transfer on the s_axis channel; tdata carries
// the six per-copy masks. One result leaves on the m_axis channel with the chosen
// copy, the fallback flag and the updated tried, skipped and speculative masks.
// Preference weights are written on the cfg channel, which is always ready; write
// them only while no request is in flight.
// A request passes through the reload check, one visit per copy in weight order
// (1 to 8 visits) and a finishing step that loads the result register behind
// m_axis_tvalid. The single rank comparator is shared by the reload check and every
// visit. A new request is taken once the previous one has reached the result
// register, so requests pass through the sequencer one at a time.
// Reset clears all weights and preference registers to zero, so the first request
// reloads every present copy to weight one unless a preference was written first.
// When the receiver stalls, the result holds in the output register; one more request
// can be worked on meanwhile and waits in its finishing state until the register frees.
module weighted_mirror_read_select_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request: present, readable, stale, tried_in, skipped_in, speculative_in,
    // eight bits each from the lowest bit up.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wmrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result: found, chosen_copy[3], by_fallback, tried_out[8], skipped_out[8],
    // speculative_out[8] from the lowest bit up, then three zero bits.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wmrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wmrs_pkg::t_idx                   i_cfg_index,
    input  wmrs_pkg::t_pref                  i_cfg_data
);
    import wmrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    t_mask             r_present, n_present;
    t_mask             r_readable, n_readable;
    t_mask             r_stale, n_stale;
    t_mask             r_tried, n_tried;
    t_mask             r_skipped, n_skipped;
    t_mask             r_spec, n_spec;
    logic [COPIES-1:0] r_visited, n_visited;
    logic              r_found, n_found;
    t_idx              r_chosen, n_chosen;
    logic              r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_weight           w_weights [COPIES];
    logic [COPIES-1:0] w_excl;
    logic              w_have;
    t_idx              w_best;
    t_weight           w_best_weight;
    t_wb_ctl           w_ctl;
    t_mask             w_bit;
    logic              w_fb_hit;
    t_idx              w_fb_idx;
    logic              w_in_xfer;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_excl = (r_state == S_CHECK) ? ~r_present[COPIES-1:0] : r_visited;
    assign w_bit  = t_mask'(1) << w_best;

    wmrs_rank u_rank (
        .i_weights     (w_weights),
        .i_excl        (w_excl),
        .o_have        (w_have),
        .o_best        (w_best),
        .o_best_weight (w_best_weight)
    );

    wmrs_weights u_weights (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .o_weights   (w_weights)
    );

    // Lowest present copy that is still untried after the scan.
    always_comb begin
        w_fb_hit = 1'b0;
        w_fb_idx = '0;
        for (int i = 0; i < COPIES; i++) begin
            if (!w_fb_hit && !r_tried[i] && r_present[i]) begin
                w_fb_hit = 1'b1;
                w_fb_idx = t_idx'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_readable  = r_readable;
        n_stale     = r_stale;
        n_tried     = r_tried;
        n_skipped   = r_skipped;
        n_spec      = r_spec;
        n_visited   = r_visited;
        n_found     = r_found;
        n_chosen    = r_chosen;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_present  = s_axis_tdata[7:0];
                    n_readable = s_axis_tdata[15:8];
                    n_stale    = s_axis_tdata[23:16];
                    n_tried    = s_axis_tdata[31:24];
                    n_skipped  = s_axis_tdata[39:32];
                    n_spec     = s_axis_tdata[47:40];
                    n_visited  = '0;
                    n_found    = 1'b0;
                    n_chosen   = '0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                // Reload when no present copy holds a positive weight.
                if (!(w_have && (w_best_weight > WEIGHT_ZERO))) begin
                    w_ctl.reload      = 1'b1;
                    w_ctl.reload_mask = r_present[COPIES-1:0];
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_visited = r_visited | w_bit[COPIES-1:0];
                if ((r_tried & w_bit) != '0 || (r_skipped & w_bit) != '0) begin
                    // Already handled earlier for this request.
                end else if ((r_present & w_bit) == '0 || (r_readable & w_bit) == '0) begin
                    n_tried   = r_tried | w_bit;
                    n_skipped = r_skipped | w_bit;
                end else if ((r_stale & w_bit) == '0) begin
                    n_found     = 1'b1;
                    n_chosen    = w_best;
                    w_ctl.dec     = 1'b1;
                    w_ctl.dec_idx = w_best;
                end else begin
                    n_skipped = r_skipped | w_bit;
                    n_spec    = r_spec | w_bit;
                end
                if (n_found || (&n_visited)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {
                        {(OUT_DATA_W-29){1'b0}},
                        r_spec,
                        r_skipped,
                        r_tried,
                        !r_found && w_fb_hit,
                        r_found ? r_chosen : (w_fb_hit ? w_fb_idx : t_idx'(0)),
                        r_found || w_fb_hit
                    };
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_visited   <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_visited   <= n_visited;
            r_found     <= n_found;
        end
        r_present  <= n_present;
        r_readable <= n_readable;
        r_stale    <= n_stale;
        r_tried    <= n_tried;
        r_skipped  <= n_skipped;
        r_spec     <= n_spec;
        r_chosen   <= n_chosen;
        r_out_data <= n_out_data;
    end

`include "weighted_mirror_read_select_unit_assert.svh"

    `WMRS_ASSERT_NOW(a_none_is_zero, r_out_valid && !r_out_data[0], r_out_data[4:1] == 4'd0, "result without a copy carries an index or fallback flag")
    `WMRS_ASSERT_NOW(a_scan_not_done, r_state == S_SCAN, !(&r_visited), "scan step entered with every copy visited")
    `WMRS_ASSERT_NOW(a_single_weight_op, 1'b1, !(w_ctl.reload && w_ctl.dec), "reload and decrement issued together")
    `WMRS_ASSERT_NEXT(a_dec_ends_scan, w_ctl.dec, r_state == S_FIN, "scan went on after a copy was chosen")

endmodule

// ----- tb/mirror_pick_checker.sv -----
// Checker that predicts and compares every read-copy pick of the mirror read-select unit.
`timescale 1ns / 100ps

module mirror_pick_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [wmrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [wmrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  wmrs_pkg::t_idx                  i_cfg_index,
    input  wmrs_pkg::t_pref                 i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_floor_hits
);
    import wmrs_pkg::*;

    // Request layout, present mask in the lowest byte.
    typedef struct packed {
        t_mask speculative;
        t_mask skipped;
        t_mask tried;
        t_mask stale;
        t_mask readable;
        t_mask present;
    } t_read_req;

    // Result layout, found in bit 0.
    typedef struct packed {
        logic [2:0] pad;
        t_mask      speculative;
        t_mask      skipped;
        t_mask      tried;
        logic       fallback;
        t_idx       copy;
        logic       found;
    } t_pick;

    t_weight copy_wt [COPIES];
    t_pref   pref_wt [COPIES];
    t_pick   expected_picks [$];

    assign o_pending = expected_picks.size();

    task automatic predict_pick(input t_read_req rq, output t_pick pk);
        t_weight top_wt;
        t_mask   visited;
        t_mask   tried;
        t_mask   skipped;
        t_mask   spec;
        int      best;
        logic    have;
        logic    found;
        top_wt  = WEIGHT_ZERO;
        visited = '0;
        tried   = rq.tried;
        skipped = rq.skipped;
        spec    = rq.speculative;
        found   = 1'b0;
        pk      = '0;

        for (int i = 0; i < COPIES; i++) begin
            if (rq.present[i] && copy_wt[i] > top_wt) top_wt = copy_wt[i];
        end
        // No present copy has positive weight left: refill from the preferences.
        if (top_wt == WEIGHT_ZERO) begin
            for (int i = 0; i < COPIES; i++) begin
                if (rq.present[i]) copy_wt[i] = t_weight'({2'b00, pref_wt[i]}) + WEIGHT_ONE;
            end
        end

        for (int k = 0; k < COPIES && !found; k++) begin
            best = 0;
            have = 1'b0;
            for (int i = 0; i < COPIES; i++) begin
                if (!visited[i] && (!have || copy_wt[i] > copy_wt[best])) begin
                    best = i;
                    have = 1'b1;
                end
            end
            visited[best] = 1'b1;
            if (tried[best] || skipped[best]) continue;
            if (!rq.present[best] || !rq.readable[best]) begin
                tried[best]   = 1'b1;
                skipped[best] = 1'b1;
            end else if (!rq.stale[best]) begin
                if (copy_wt[best] > WEIGHT_MIN) copy_wt[best] = copy_wt[best] - WEIGHT_ONE;
                else o_floor_hits++;
                found   = 1'b1;
                pk.copy = t_idx'(best);
            end else begin
                skipped[best] = 1'b1;
                spec[best]    = 1'b1;
            end
        end

        // Nothing readable and fresh: hand out the lowest untried present copy.
        if (!found) begin
            for (int i = 0; i < COPIES && !found; i++) begin
                if (!tried[i] && rq.present[i]) begin
                    found       = 1'b1;
                    pk.copy     = t_idx'(i);
                    pk.fallback = 1'b1;
                end
            end
        end

        pk.found       = found;
        pk.tried       = tried;
        pk.skipped     = skipped;
        pk.speculative = spec;
    endtask

    task automatic report_pick(input string what, input t_pick want, input t_pick got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%t %s", $realtime, what);
            $display("  expected found=%0d copy=%0d fallback=%0d tried=%02h skipped=%02h spec=%02h pad=%0h",
                     want.found, want.copy, want.fallback, want.tried, want.skipped,
                     want.speculative, want.pad);
            $display("  actual   found=%0d copy=%0d fallback=%0d tried=%02h skipped=%02h spec=%02h pad=%0h",
                     got.found, got.copy, got.fallback, got.tried, got.skipped,
                     got.speculative, got.pad);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_floor_hits = 0;
    end

    always @(posedge i_clk) begin
        t_pick want;
        t_pick got;
        if (!i_rst_n) begin
            for (int i = 0; i < COPIES; i++) begin
                copy_wt[i] = WEIGHT_ZERO;
                pref_wt[i] = '0;
            end
            expected_picks.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) pref_wt[i_cfg_index] = i_cfg_data;

            if (m_axis_tvalid && m_axis_tready) begin
                got = t_pick'(m_axis_tdata);
                if (expected_picks.size() == 0) begin
                    report_pick("result transfer with no request outstanding", '0, got);
                end else begin
                    want = expected_picks.pop_front();
                    o_checked++;
                    if (got.found !== want.found || got.copy !== want.copy ||
                        got.fallback !== want.fallback || got.tried !== want.tried ||
                        got.skipped !== want.skipped || got.speculative !== want.speculative ||
                        got.pad !== want.pad)
                        report_pick("result mismatch", want, got);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_pick(t_read_req'(s_axis_tdata), want);
                expected_picks.push_back(want);
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the mirror read-select unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import wmrs_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int FLOOR_ITEMS   = 530;
    localparam int PHASE_ITEMS   = 210;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_idx                  i_cfg_index   = '0;
    t_pref                 i_cfg_data    = '0;

    int   fail_count;
    int   pending;
    int   checked;
    int   floor_hits;
    int   quiet_cycles = 0;
    int   sent         = 0;
    int   cfg_writes   = 0;
    logic steady       = 1'b0;

    weighted_mirror_read_select_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    mirror_pick_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_floor_hits (floor_hits)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 27);
    end

    // Any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_req(input t_mask pr, input t_mask rd,
                                                      input t_mask st, input t_mask tr,
                                                      input t_mask sk, input t_mask sp);
        return {sp, sk, tr, st, rd, pr};
    endfunction

    function automatic t_mask mask_pct(input int pct);
        t_mask m;
        for (int i = 0; i < MASK_W; i++) m[i] = ($urandom_range(99) < pct);
        return m;
    endfunction

    function automatic t_mask corner_mask();
        t_mask one;
        one = t_mask'(1) << $urandom_range(MASK_W - 1);
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return one;
            default: return ~one;
        endcase
    endfunction

    // Mostly plausible requests with few marks already set, otherwise raw noise and corners.
    function automatic logic [IN_DATA_W-1:0] rand_req();
        int    mode;
        t_mask sk;
        mode = $urandom_range(99);
        if (mode < 60) begin
            sk = mask_pct(12);
            return pack_req(mask_pct(85), mask_pct(80), mask_pct(20), mask_pct(12), sk,
                            sk & mask_pct(50));
        end else if (mode < 85) begin
            return pack_req(t_mask'($urandom), t_mask'($urandom), t_mask'($urandom),
                            t_mask'($urandom), t_mask'($urandom), t_mask'($urandom));
        end
        return pack_req(corner_mask(), corner_mask(), corner_mask(), corner_mask(),
                        corner_mask(), corner_mask());
    endfunction

    // Copy 0 stays present but tried, so copy 1 is picked every time and its weight sinks
    // to the floor while copy 0 keeps a positive weight that blocks the refill.
    function automatic logic [IN_DATA_W-1:0] floor_req();
        return pack_req(8'h03, 8'h02 | t_mask'($urandom), t_mask'($urandom) & 8'hFD,
                        8'h01 | (t_mask'($urandom) & 8'hFC), t_mask'($urandom) & 8'hFC,
                        t_mask'($urandom));
    endfunction

    // Valid stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_req(input logic [IN_DATA_W-1:0] d);
        if (!steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 27) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_prefs(input logic [COPIES*PREF_W-1:0] vals);
        for (int i = 0; i < COPIES; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_idx'(i);
            i_cfg_data  <= vals[i*PREF_W +: PREF_W];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [COPIES*PREF_W-1:0] prefs, input logic no_idle);
        write_prefs(prefs);
        steady = no_idle;
        for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_req());
        drain();
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset preferences, so every refill gives weight one.
        send_req(pack_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'h0F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hF0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF));
        send_req(pack_req(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'hAA, 8'hFF, 8'h00, 8'h0A, 8'h20, 8'h20));
        send_req(pack_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_req(pack_req(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'h03, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00));
        send_req(pack_req(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        drain();

        // Drive copy 1 down to the weight floor and hold it there for a while.
        write_prefs({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | 64'h0000_0000_0000_00FF);
        for (int n = 0; n < FLOOR_ITEMS; n++) send_req(floor_req());
        drain();

        run_phase({COPIES{8'hFF}}, 1'b0);
        run_phase({$urandom, $urandom}, 1'b0);
        run_phase(64'hFF00_FF00_FF00_FF00, 1'b0);
        run_phase({COPIES{8'h00}}, 1'b0);
        run_phase({$urandom, $urandom}, 1'b1);

        $display("%0d read requests sent under seven preference settings (%0d register writes)",
                 sent, cfg_writes);
        $display("%0d results checked, weight floor held %0d times, %0d mismatches",
                 checked, floor_hits, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wmrs_pkg.sv
rtl/wmrs_rank.sv
rtl/wmrs_weights.sv
rtl/weighted_mirror_read_select_unit.sv
tb/mirror_pick_checker.sv
tb/tb_top.sv
